// ----- src/rgbxf_pkg.sv -----
// Shared constants, types and helpers of the RGB cross-fade and flash controller.
`default_nettype none

package rgbxf_pkg;

    localparam int LEVEL_W     = 8;
    localparam int FADE_W      = 11;   // fade step counter and divider dividend
    localparam int DIVISOR_W   = 10;   // step magnitude, up to FADE_SPAN
    localparam int SINCE_W     = 17;
    localparam int TRANS_W     = 16;
    localparam int FLASH_W     = 18;
    localparam int PHASE_W     = 10;

    localparam logic [FADE_W-1:0]    FADE_SPAN    = 11'd1020;
    localparam logic [FLASH_W-1:0]   FLASH_PERIOD = 18'd1000;
    localparam logic [PHASE_W-1:0]   PHASE_LAST   = 10'd999;
    localparam logic [PHASE_W-1:0]   FLASH_ON     = 10'd500;
    localparam logic [LEVEL_W-1:0]   LEVEL_MAX    = 8'd255;
    localparam logic [SINCE_W-1:0]   SINCE_MAX    = 17'd131071;
    localparam logic [FLASH_W-1:0]   ELAPSED_MAX  = 18'd262143;

    localparam logic KIND_COLOR  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef struct packed {
        logic                 done;
        logic [FADE_W-1:0]    quot;
        logic [DIVISOR_W-1:0] rem;
    } div_res_t;

    // Exact floor(p / 255) for any product of two 8-bit levels
    function automatic logic [LEVEL_W-1:0] div255(input logic [15:0] p);
        logic [16:0] t;
        begin
            t = {1'b0, p} + {9'b0, p[15:8]} + 17'd1;
            div255 = t[15:8];
        end
    endfunction

endpackage

`default_nettype wire

// ----- src/rgb_crossfade_flash_controller.sv -----
// Top level: RGB cross-fade and flash controller with a shared divider and multiplier.
//
//  channel | handshake         | payload
//  --------+-------------------+--------------------------------------------------
//  input   | in_valid/in_ready | command, power/color/brightness/flash fields
//  output  | out_valid/out_ready | kind, out_red/green/blue, out_brightness, out_power, last
//
// A set request does one 8x8 multiply per channel, first for the flash color when
// a flash is given, then for the target color. Each divide on the shared 11-step
// divider holds the sequencer: one per channel with a nonzero difference for the
// step values at fade start, and one per channel with a nonzero step for step timing
// on each fade step. One transaction is worked at a time.
// Reset restores all stored state at once. A stalled output holds the sequencer.
`default_nettype none

module rgb_crossfade_flash_controller (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       command,
    input  wire logic       power_given,
    input  wire logic       power_on,
    input  wire logic       color_given,
    input  wire logic [7:0] red_in,
    input  wire logic [7:0] green_in,
    input  wire logic [7:0] blue_in,
    input  wire logic       brightness_given,
    input  wire logic [7:0] brightness_in,
    input  wire logic [15:0] transition_ms,
    input  wire logic       flash_given,
    input  wire logic [7:0] flash_seconds,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            kind,
    output logic [7:0]      out_red,
    output logic [7:0]      out_green,
    output logic [7:0]      out_blue,
    output logic [7:0]      out_brightness,
    output logic            out_power,
    output logic            last
);
    import rgbxf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SET, S_SMUL, S_SWR, S_REPORT,
        S_TICK, S_FLASH, S_FADE, S_TGTOUT,
        S_STEP, S_STEPW, S_FADING, S_MOD, S_MODW, S_FADEOUT
    } state_t;

    state_t state_reg;

    // latched request
    logic               pg_reg, po_reg, cg_reg, bg_reg, fg_reg;
    logic [LEVEL_W-1:0] col_reg [3];
    logic [LEVEL_W-1:0] bri_reg;
    logic [TRANS_W-1:0] trn_reg;
    logic [LEVEL_W-1:0] fsec_reg;

    // controller state
    logic [LEVEL_W-1:0]   stored_rgb_reg  [3];
    logic [LEVEL_W-1:0]   target_rgb_reg  [3];
    logic [LEVEL_W-1:0]   current_rgb_reg [3];
    logic [LEVEL_W-1:0]   flash_rgb_reg   [3];
    logic [DIVISOR_W-1:0] step_mag_reg    [3];
    logic                 step_neg_reg    [3];
    logic [LEVEL_W-1:0]   stored_bri_reg;
    logic                 power_reg;
    logic [FADE_W-1:0]    counter_reg;
    logic [SINCE_W-1:0]   since_reg;
    logic [TRANS_W-1:0]   trans_reg;
    logic                 flash_reg, flash_start_reg, fade_start_reg, fading_reg;
    logic [FLASH_W-1:0]   flash_len_reg;
    logic [FLASH_W-1:0]   elapsed_reg;
    logic [PHASE_W-1:0]   phase_reg;

    // sequencer working registers
    logic [1:0]  ch_reg;
    logic        scale_tgt_reg;
    logic [15:0] prod_reg;

    // output register
    logic               out_valid_reg, kind_reg, power_out_reg, last_reg;
    logic [LEVEL_W-1:0] red_reg, green_reg, blue_reg, bri_out_reg;

    logic                 in_acc;
    logic                 out_free;
    logic                 out_load;
    logic [LEVEL_W-1:0]   mul_a, mul_b;
    logic [LEVEL_W-1:0]   tgt_c, cur_c;
    logic                 d_neg;
    logic [LEVEL_W-1:0]   d_mag;
    logic [LEVEL_W-1:0]   cur_stepped;
    logic                 fade_emit;
    logic                 div_start;
    logic [FADE_W-1:0]    div_dividend;
    logic [DIVISOR_W-1:0] div_divisor;
    div_res_t             div_res;

    assign in_ready = (state_reg == S_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        tgt_c = target_rgb_reg[ch_reg];
        cur_c = current_rgb_reg[ch_reg];
        d_neg = tgt_c < cur_c;
        d_mag = d_neg ? (cur_c - tgt_c) : (tgt_c - cur_c);

        if (step_neg_reg[ch_reg])
            cur_stepped = (cur_c == 8'd0) ? 8'd0 : cur_c - 8'd1;
        else
            cur_stepped = (cur_c == LEVEL_MAX) ? LEVEL_MAX : cur_c + 8'd1;

        if (scale_tgt_reg)
        begin
            mul_a = stored_rgb_reg[ch_reg];
            mul_b = stored_bri_reg;
        end
        else
        begin
            mul_a = cg_reg ? col_reg[ch_reg] : stored_rgb_reg[ch_reg];
            mul_b = bg_reg ? bri_reg : stored_bri_reg;
        end

        // load the output register from any writing state once it is free
        out_load = out_free && (state_reg inside {S_REPORT, S_FLASH, S_TGTOUT, S_FADEOUT});

        // does the fade part of this tick write a color after the flash write
        fade_emit = (fade_start_reg && trans_reg == '0)
                 || ((fade_start_reg || fading_reg)
                     && since_reg > {1'b0, trans_reg}
                     && (fade_start_reg || counter_reg <= FADE_SPAN));

        div_start    = 1'b0;
        div_dividend = counter_reg;
        div_divisor  = step_mag_reg[ch_reg];
        if (state_reg == S_STEP)
        begin
            div_start    = (d_mag != 8'd0);
            div_dividend = FADE_SPAN;
            div_divisor  = {2'b00, d_mag};
        end
        else if (state_reg == S_MOD)
        begin
            div_start = (step_mag_reg[ch_reg] != '0);
        end
    end

    rgbxf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .res      (div_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            pg_reg          <= 1'b0;
            po_reg          <= 1'b0;
            cg_reg          <= 1'b0;
            bg_reg          <= 1'b0;
            fg_reg          <= 1'b0;
            bri_reg         <= '0;
            trn_reg         <= '0;
            fsec_reg        <= '0;
            for (int i = 0; i < 3; i++)
            begin
                col_reg[i]         <= '0;
                stored_rgb_reg[i]  <= LEVEL_MAX;
                target_rgb_reg[i]  <= '0;
                current_rgb_reg[i] <= '0;
                flash_rgb_reg[i]   <= LEVEL_MAX;
                step_mag_reg[i]    <= '0;
                step_neg_reg[i]    <= 1'b0;
            end
            stored_bri_reg  <= LEVEL_MAX;
            power_reg       <= 1'b0;
            counter_reg     <= '0;
            since_reg       <= '0;
            trans_reg       <= '0;
            flash_reg       <= 1'b0;
            flash_start_reg <= 1'b0;
            fade_start_reg  <= 1'b0;
            fading_reg      <= 1'b0;
            flash_len_reg   <= '0;
            elapsed_reg     <= '0;
            phase_reg       <= '0;
            ch_reg          <= '0;
            scale_tgt_reg   <= 1'b0;
            prod_reg        <= '0;
            out_valid_reg   <= 1'b0;
            kind_reg        <= KIND_COLOR;
            power_out_reg   <= 1'b0;
            last_reg        <= 1'b0;
            red_reg         <= '0;
            green_reg       <= '0;
            blue_reg        <= '0;
            bri_out_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_load || (out_valid_reg && !out_ready);

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        pg_reg     <= power_given;
                        po_reg     <= power_on;
                        cg_reg     <= color_given;
                        col_reg[0] <= red_in;
                        col_reg[1] <= green_in;
                        col_reg[2] <= blue_in;
                        bg_reg     <= brightness_given;
                        bri_reg    <= brightness_in;
                        trn_reg    <= transition_ms;
                        fg_reg     <= flash_given;
                        fsec_reg   <= flash_seconds;
                        state_reg  <= command ? S_SET : S_TICK;
                    end
                end

                S_SET:
                begin
                    if (pg_reg)
                        power_reg <= po_reg;
                    if (fg_reg)
                    begin
                        flash_len_reg   <= {10'b0, fsec_reg} * FLASH_PERIOD;
                        flash_reg       <= 1'b1;
                        flash_start_reg <= 1'b1;
                        scale_tgt_reg   <= 1'b0;
                    end
                    else
                    begin
                        flash_reg <= 1'b0;
                        if (cg_reg)
                            for (int i = 0; i < 3; i++)
                                stored_rgb_reg[i] <= col_reg[i];
                        if (bg_reg)
                            stored_bri_reg <= bri_reg;
                        trans_reg     <= trn_reg;
                        scale_tgt_reg <= 1'b1;
                    end
                    ch_reg    <= 2'd0;
                    state_reg <= S_SMUL;
                end

                S_SMUL:
                begin
                    prod_reg  <= {8'b0, mul_a} * {8'b0, mul_b};
                    state_reg <= S_SWR;
                end

                S_SWR:
                begin
                    if (scale_tgt_reg)
                        target_rgb_reg[ch_reg] <= power_reg ? div255(prod_reg) : 8'd0;
                    else
                        flash_rgb_reg[ch_reg] <= div255(prod_reg);
                    if (ch_reg == 2'd2)
                    begin
                        ch_reg <= 2'd0;
                        if (scale_tgt_reg)
                        begin
                            fade_start_reg <= 1'b1;
                            fading_reg     <= 1'b0;
                            state_reg      <= S_REPORT;
                        end
                        else
                        begin
                            scale_tgt_reg <= 1'b1;
                            state_reg     <= S_SMUL;
                        end
                    end
                    else
                    begin
                        ch_reg    <= ch_reg + 2'd1;
                        state_reg <= S_SMUL;
                    end
                end

                S_REPORT:
                begin
                    if (out_free)
                    begin
                        kind_reg      <= KIND_REPORT;
                        red_reg       <= stored_rgb_reg[0];
                        green_reg     <= stored_rgb_reg[1];
                        blue_reg      <= stored_rgb_reg[2];
                        bri_out_reg   <= stored_bri_reg;
                        power_out_reg <= power_reg;
                        last_reg      <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                S_TICK:
                begin
                    if (since_reg != SINCE_MAX)
                        since_reg <= since_reg + 17'd1;
                    if (flash_reg)
                    begin
                        if (flash_start_reg)
                        begin
                            flash_start_reg <= 1'b0;
                            elapsed_reg     <= '0;
                            phase_reg       <= '0;
                        end
                        else
                        begin
                            if (elapsed_reg != ELAPSED_MAX)
                                elapsed_reg <= elapsed_reg + 18'd1;
                            // track elapsed mod 1000 alongside
                            phase_reg <= (phase_reg == PHASE_LAST) ? '0 : phase_reg + 10'd1;
                        end
                        state_reg <= S_FLASH;
                    end
                    else
                        state_reg <= S_FADE;
                end

                S_FLASH:
                begin
                    if (out_free)
                    begin
                        kind_reg      <= KIND_COLOR;
                        bri_out_reg   <= '0;
                        power_out_reg <= 1'b0;
                        last_reg      <= !fade_emit;
                        if (elapsed_reg <= flash_len_reg)
                        begin
                            if (phase_reg <= FLASH_ON)
                            begin
                                red_reg   <= flash_rgb_reg[0];
                                green_reg <= flash_rgb_reg[1];
                                blue_reg  <= flash_rgb_reg[2];
                            end
                            else
                            begin
                                red_reg   <= '0;
                                green_reg <= '0;
                                blue_reg  <= '0;
                            end
                        end
                        else
                        begin
                            flash_reg <= 1'b0;
                            red_reg   <= target_rgb_reg[0];
                            green_reg <= target_rgb_reg[1];
                            blue_reg  <= target_rgb_reg[2];
                        end
                        state_reg <= S_FADE;
                    end
                end

                S_FADE:
                begin
                    if (fade_start_reg)
                    begin
                        if (trans_reg == '0)
                            state_reg <= S_TGTOUT;
                        else
                        begin
                            counter_reg <= '0;
                            ch_reg      <= 2'd0;
                            state_reg   <= S_STEP;
                        end
                    end
                    else if (fading_reg)
                        state_reg <= S_FADING;
                    else
                        state_reg <= S_IDLE;
                end

                S_TGTOUT:
                begin
                    if (out_free)
                    begin
                        kind_reg      <= KIND_COLOR;
                        red_reg       <= target_rgb_reg[0];
                        green_reg     <= target_rgb_reg[1];
                        blue_reg      <= target_rgb_reg[2];
                        bri_out_reg   <= '0;
                        power_out_reg <= 1'b0;
                        last_reg      <= 1'b1;
                        for (int i = 0; i < 3; i++)
                            current_rgb_reg[i] <= target_rgb_reg[i];
                        fade_start_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end

                S_STEP:
                begin
                    step_neg_reg[ch_reg] <= d_neg;
                    if (d_mag == 8'd0)
                    begin
                        step_mag_reg[ch_reg] <= '0;
                        if (ch_reg == 2'd2)
                        begin
                            fading_reg <= 1'b1;
                            state_reg  <= S_FADING;
                        end
                        else
                            ch_reg <= ch_reg + 2'd1;
                    end
                    else
                        state_reg <= S_STEPW;
                end

                S_STEPW:
                begin
                    if (div_res.done)
                    begin
                        step_mag_reg[ch_reg] <= div_res.quot[DIVISOR_W-1:0];
                        if (ch_reg == 2'd2)
                        begin
                            fading_reg <= 1'b1;
                            state_reg  <= S_FADING;
                        end
                        else
                        begin
                            ch_reg    <= ch_reg + 2'd1;
                            state_reg <= S_STEP;
                        end
                    end
                end

                S_FADING:
                begin
                    fade_start_reg <= 1'b0;
                    if (since_reg > {1'b0, trans_reg})
                    begin
                        if (counter_reg <= FADE_SPAN)
                        begin
                            since_reg <= '0;
                            ch_reg    <= 2'd0;
                            state_reg <= S_MOD;
                        end
                        else
                        begin
                            fading_reg <= 1'b0;
                            state_reg  <= S_IDLE;
                        end
                    end
                    else
                        state_reg <= S_IDLE;
                end

                S_MOD:
                begin
                    if (step_mag_reg[ch_reg] == '0)
                    begin
                        if (ch_reg == 2'd2)
                            state_reg <= S_FADEOUT;
                        else
                            ch_reg <= ch_reg + 2'd1;
                    end
                    else
                        state_reg <= S_MODW;
                end

                S_MODW:
                begin
                    if (div_res.done)
                    begin
                        // move one level when the step count is a multiple of the step
                        if (div_res.rem == '0)
                            current_rgb_reg[ch_reg] <= cur_stepped;
                        if (ch_reg == 2'd2)
                            state_reg <= S_FADEOUT;
                        else
                        begin
                            ch_reg    <= ch_reg + 2'd1;
                            state_reg <= S_MOD;
                        end
                    end
                end

                S_FADEOUT:
                begin
                    if (out_free)
                    begin
                        kind_reg      <= KIND_COLOR;
                        red_reg       <= current_rgb_reg[0];
                        green_reg     <= current_rgb_reg[1];
                        blue_reg      <= current_rgb_reg[2];
                        bri_out_reg   <= '0;
                        power_out_reg <= 1'b0;
                        last_reg      <= 1'b1;
                        counter_reg   <= counter_reg + 11'd1;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign out_red        = red_reg;
    assign out_green      = green_reg;
    assign out_blue       = blue_reg;
    assign out_brightness = bri_out_reg;
    assign out_power      = power_out_reg;
    assign last           = last_reg;

endmodule

`default_nettype wire

// ----- src/rgbxf_div.sv -----
// Iterative restoring divider: one quotient bit per cycle, quotient and remainder out.
`default_nettype none

module rgbxf_div (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [rgbxf_pkg::FADE_W-1:0]    dividend,
    input  wire logic [rgbxf_pkg::DIVISOR_W-1:0] divisor,
    output rgbxf_pkg::div_res_t                  res
);
    import rgbxf_pkg::*;

    localparam logic [3:0] ITER = 4'(FADE_W);

    logic                 busy_reg;
    logic                 done_reg;
    logic [3:0]           cnt_reg;
    logic [FADE_W-1:0]    quot_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] dsr_reg;

    logic [DIVISOR_W:0]   shifted;
    logic [DIVISOR_W:0]   trial;
    logic                 fits;

    always_comb
    begin
        shifted = {rem_reg, quot_reg[FADE_W-1]};
        trial   = shifted - {1'b0, dsr_reg};
        fits    = shifted >= {1'b0, dsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quot_reg <= '0;
            rem_reg  <= '0;
            dsr_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ITER;
                quot_reg <= dividend;
                rem_reg  <= '0;
                dsr_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                rem_reg  <= fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
                quot_reg <= {quot_reg[FADE_W-2:0], fits};
                cnt_reg  <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign res.done = done_reg;
    assign res.quot = quot_reg;
    assign res.rem  = rem_reg;

endmodule

`default_nettype wire
